FILE: src/keyed_move_book_random_pick_defines.svh
// Assertion macros for the keyed move book.
// Taken in by the top level; depends on nothing else.
`ifndef KEYED_MOVE_BOOK_RANDOM_PICK_DEFINES_SVH
`define KEYED_MOVE_BOOK_RANDOM_PICK_DEFINES_SVH
`ifndef SYNTHESIS
`define KMB_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("kmb assertion failed");
`define KMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmb assertion failed");
`define KMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmb assertion failed");
`else
`define KMB_ASSERT(lbl, clk, rst_n, expr)
`define KMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/kmb_pkg.sv
// Shared types and constants for the keyed move book.
// No dependencies; imported by the top level.
`default_nettype none

package kmb_pkg;

    localparam int KEY_ENTRIES_DEF   = 256;
    localparam int MOVES_PER_KEY_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int MOVE_W   = 32;
    localparam int RND_W    = 32;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [MOVE_W-1:0]   move_t;
    typedef logic [RND_W-1:0]    rnd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ADD   = 2'd0;
    localparam cmd_t CMD_GET   = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

endpackage

`default_nettype wire

FILE: src/keyed_move_book_random_pick.sv
// Keyed move book: maps 64-bit position keys to short lists of 32-bit moves.
// Input channel (in_valid/in_ready) carries cmd, key, move_value and
// random_value; the output channel (out_valid/out_ready) carries move_out and
// status, exactly one result per request.
// An add scans the keys in use, claims a new slot if the key is absent and
// appends the move. A get scans for the key, takes random_value modulo the
// move count with a one-bit-per-cycle restoring divider and reads that move.
// A clear empties the table.
// A get passes through the key scan (S_SCAN and S_CMP for each slot
// compared), the count read, the modulo, the move read and the output load.
// A key miss ends after the scan; an add on a known key reads its count and
// then appends in S_APPEND, and a new key goes from the scan to S_APPEND.
// A clear goes straight from S_IDLE to S_DONE.
// One request is in work at a time; in_ready is high only while idle, so a
// new request is taken at the earliest in the cycle after the last result loads.
// A finished result sits in an output register, so the next request is taken
// while it waits; if the receiver still stalls when that one finishes, the
// block holds it until out_ready. Reset empties the table and the output.
// Stores need no clearing pass: only slots below the used count are read.
`default_nettype none
`include "keyed_move_book_random_pick_defines.svh"

module keyed_move_book_random_pick #(
    parameter int KEY_ENTRIES   = kmb_pkg::KEY_ENTRIES_DEF,
    parameter int MOVES_PER_KEY = kmb_pkg::MOVES_PER_KEY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire kmb_pkg::cmd_t    cmd,
    input  wire kmb_pkg::key_t    key,
    input  wire kmb_pkg::move_t   move_value,
    input  wire kmb_pkg::rnd_t    random_value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output kmb_pkg::move_t        move_out,
    output kmb_pkg::status_t      status
);

    import kmb_pkg::*;

    localparam int SLOT_W   = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
    localparam int KU_W     = $clog2(KEY_ENTRIES + 1);
    localparam int CW       = $clog2(MOVES_PER_KEY + 1);
    localparam int OFF_W    = (MOVES_PER_KEY > 1) ? $clog2(MOVES_PER_KEY) : 1;
    localparam int MV_DEPTH = KEY_ENTRIES * MOVES_PER_KEY;
    localparam int MA_W     = (MV_DEPTH > 1) ? $clog2(MV_DEPTH) : 1;
    localparam int DC_W     = $clog2(RND_W);

    localparam logic [KU_W-1:0] KU_MAX  = KU_W'(KEY_ENTRIES);
    localparam logic [CW-1:0]   CNT_MAX = CW'(MOVES_PER_KEY);
    localparam logic [DC_W-1:0] DIV_END = DC_W'(RND_W - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_CMP     = 4'd2;
    localparam logic [3:0] S_CNT_RD  = 4'd3;
    localparam logic [3:0] S_CNT_USE = 4'd4;
    localparam logic [3:0] S_APPEND  = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_MV_RD   = 4'd7;
    localparam logic [3:0] S_MV_USE  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [KU_W-1:0]   keys_used_reg, keys_used_next;
    logic [KU_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rem_reg, rem_next;
    rnd_t              div_reg, div_next;
    logic [DC_W-1:0]   step_reg, step_next;
    cmd_t              cmd_reg, cmd_next;
    key_t              key_reg, key_next;
    move_t             mv_reg, mv_next;
    move_t             res_move_reg, res_move_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    move_t             move_out_reg, move_out_next;
    status_t           status_reg, status_next;

    logic              key_we;
    key_t              key_rdata;
    logic              cnt_we;
    logic [CW-1:0]     cnt_rdata;
    logic              mv_we;
    move_t             mv_rdata;
    logic [MA_W-1:0]   row_base;
    logic [MA_W-1:0]   mv_waddr;
    logic [MA_W-1:0]   mv_raddr;
    logic [CW:0]       trial;
    logic [CW:0]       trial_sub;
    logic              out_free;

    assign row_base = MA_W'(slot_reg) * MA_W'(MOVES_PER_KEY);
    assign mv_waddr = row_base + MA_W'(count_reg[OFF_W-1:0]);
    assign mv_raddr = row_base + MA_W'(rem_reg[OFF_W-1:0]);

    // Restoring division step: shift in the next dividend bit, subtract if it fits.
    assign trial     = {rem_reg, div_reg[RND_W-1]};
    assign trial_sub = trial - {1'b0, count_reg};

    assign out_free = !out_valid_reg || out_ready;

    kmb_ram #(.WIDTH(KEY_W), .DEPTH(KEY_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (keys_used_reg[SLOT_W-1:0]),
        .wdata (key_reg),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (key_rdata)
    );

    kmb_ram #(.WIDTH(CW), .DEPTH(KEY_ENTRIES)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (slot_reg),
        .wdata (count_reg + CW'(1)),
        .raddr (slot_reg),
        .rdata (cnt_rdata)
    );

    kmb_ram #(.WIDTH(MOVE_W), .DEPTH(MV_DEPTH)) u_mv_ram (
        .clk   (clk),
        .we    (mv_we),
        .waddr (mv_waddr),
        .wdata (mv_reg),
        .raddr (mv_raddr),
        .rdata (mv_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        keys_used_next  = keys_used_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        mv_next         = mv_reg;
        res_move_next   = res_move_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        move_out_next   = move_out_reg;
        status_next     = status_reg;
        key_we          = 1'b0;
        cnt_we          = 1'b0;
        mv_we           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    key_next        = key;
                    mv_next         = move_value;
                    div_next        = random_value;
                    idx_next        = '0;
                    res_move_next   = '0;
                    res_status_next = ST_OK;
                    if (cmd == CMD_ADD || cmd == CMD_GET)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        if (cmd == CMD_CLEAR)
                        begin
                            keys_used_next = '0;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg == keys_used_reg)
                begin
                    if (cmd_reg == CMD_GET)
                    begin
                        res_status_next = ST_MISS;
                        state_next      = S_DONE;
                    end
                    else if (keys_used_reg == KU_MAX)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // New key: claim the next free slot with an empty list.
                        key_we         = 1'b1;
                        slot_next      = keys_used_reg[SLOT_W-1:0];
                        keys_used_next = keys_used_reg + KU_W'(1);
                        count_next     = '0;
                        state_next     = S_APPEND;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_rdata == key_reg)
                begin
                    slot_next  = idx_reg[SLOT_W-1:0];
                    state_next = S_CNT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + KU_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_CNT_RD:
            begin
                state_next = S_CNT_USE;
            end
            S_CNT_USE:
            begin
                count_next = cnt_rdata;
                if (cmd_reg == CMD_ADD)
                begin
                    state_next = S_APPEND;
                end
                else if (cnt_rdata == '0)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_APPEND:
            begin
                if (count_reg >= CNT_MAX)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    mv_we  = 1'b1;
                    cnt_we = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, count_reg})
                begin
                    rem_next = trial_sub[CW-1:0];
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                end
                div_next  = {div_reg[RND_W-2:0], 1'b0};
                step_next = step_reg + DC_W'(1);
                if (step_reg == DIV_END)
                begin
                    state_next = S_MV_RD;
                end
            end
            S_MV_RD:
            begin
                state_next = S_MV_USE;
            end
            S_MV_USE:
            begin
                res_move_next = mv_rdata;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    move_out_next  = res_move_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            keys_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keys_used_reg <= keys_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        slot_reg       <= slot_next;
        count_reg      <= count_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        mv_reg         <= mv_next;
        res_move_reg   <= res_move_next;
        res_status_reg <= res_status_next;
        move_out_reg   <= move_out_next;
        status_reg     <= status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign move_out  = move_out_reg;
    assign status    = status_reg;

    `KMB_ASSERT(a_keys_bound, clk, rst_n, keys_used_reg <= KU_MAX)
    `KMB_ASSERT_IMP(a_append_room, clk, rst_n, mv_we, count_reg < CNT_MAX && cnt_we)
    `KMB_ASSERT_IMP(a_rem_bound, clk, rst_n, state_reg == S_MV_RD, rem_reg < count_reg)
    `KMB_ASSERT_NEXT(a_done_loads, clk, rst_n, state_reg == S_DONE && out_free, out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

FILE: src/kmb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module kmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
